// File: design/ftdpq_pkg.sv
// shared types and constants for the tail-drop packet queue
`timescale 1ns / 1ps

package ftdpq_pkg;

  localparam int TIME_W = 48;
  localparam int ID_W   = 16;
  localparam int LEN_W  = 16;
  localparam int CAP_W  = 20;
  localparam int TPB_W  = 32;
  localparam int BYTES_W = 21;
  localparam int PROD_W = LEN_W + TPB_W;

  // queued packet, departure time in the lowest bits
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] depart;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // configuration register indexes
  typedef enum logic {
    REG_CAPACITY      = 1'b0,
    REG_TIME_PER_BYTE = 1'b1
  } cfg_reg_t;

  // input word selector
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_FLUSH   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// File: design/ftdpq_entry_ram.sv
// packet entry store: one write port, one registered read port
`timescale 1ns / 1ps

module ftdpq_entry_ram import ftdpq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/ftdpq_out_reg.sv
// result output register, parts the drain sequencer from the sink
`timescale 1ns / 1ps

module ftdpq_out_reg import ftdpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  entry_t             push_entry,
  input  logic               push_last,
  output logic               free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ENTRY_W-1:0] out_tdata,
  output logic               out_tlast
);

  logic   valid_r;
  entry_t data_r;
  logic   last_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_entry;
      last_r <= push_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// File: design/fifo_tail_drop_packet_queue.sv
// top level: byte-limited tail-drop packet queue with drain sequencer
// sequence: a word is taken while idle; each departure then moves through the hold slot,
//   and a closing step marks the last word and writes the admission to the store
// flow: a full output register stalls the drain; a new word is taken only back in idle; an
//   oversized arrival is dropped as it is accepted; the store is read ahead (registered read)
// reset: synchronous active-low; pointers, counts, tail time and hold flag cleared, config
//   set to defaults, entry store not cleared (only entries holding a packet are ever read)
`timescale 1ns / 1ps

module fifo_tail_drop_packet_queue import ftdpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ENTRY_W-1:0] in_tdata,   // arr_time, pkt_id, pkt_length
  input  logic               in_tuser,   // cmd
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ENTRY_W-1:0] out_tdata,  // depart_time, out_id, out_length
  output logic               out_tlast,  // last
  // configuration writes
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [TPB_W-1:0]   cfg_wdata
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

  // sequencer and queue state
  state_t             state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [TIME_W-1:0]  tail_dep_r, tail_dep_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  entry_t             hold_r, hold_nxt;

  // configuration registers
  logic [CAP_W-1:0]   cap_r;
  logic [TPB_W-1:0]   tpb_r;

  // latched input word
  logic               flush_r;
  logic [TIME_W-1:0]  arr_r;
  logic [ID_W-1:0]    id_r;
  logic [LEN_W-1:0]   len_r;
  logic [PROD_W-1:0]  prod_r;

  // input word fields
  logic [TIME_W-1:0]  in_arr;
  logic [ID_W-1:0]    in_id;
  logic [LEN_W-1:0]   in_len;
  logic               in_accept;

  assign in_arr = in_tdata[TIME_W-1:0];
  assign in_id  = in_tdata[TIME_W+ID_W-1:TIME_W];
  assign in_len = in_tdata[ENTRY_W-1:TIME_W+ID_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // store ports
  entry_t        rd_entry;
  logic          wr_en;
  entry_t        wr_entry;

  // output register handshake
  logic          out_push;
  entry_t        out_entry;
  logic          out_last;
  logic          out_free;

  // drain decision and admission
  logic               can_emit;
  logic               stall;
  logic               admit;
  logic [TIME_W-1:0]  dep_base;
  logic [TIME_W:0]    dep_sum;
  logic [TIME_W-1:0]  dep_time;
  logic [BYTES_W:0]   bytes_after;

  // head entry is read ahead: the store is addressed with the next head pointer
  assign can_emit = (count_r != '0) &&
                    (flush_r || (rd_entry.depart <= arr_r));

  // a held result must go out before the hold slot can be reused
  assign stall = hold_valid_r && !out_free;

  assign bytes_after = {1'b0, bytes_r} + {{(BYTES_W + 1 - LEN_W){1'b0}}, len_r};
  assign admit = !flush_r && (count_r < CW'(QUEUE_DEPTH)) &&
                 (bytes_after <= {{(BYTES_W + 1 - CAP_W){1'b0}}, cap_r});

  // departure base is the tail's departure if the queue is busy and later
  assign dep_base = ((count_r != '0) && (tail_dep_r > arr_r)) ? tail_dep_r : arr_r;
  assign dep_sum  = {1'b0, dep_base} + {{(TIME_W + 1 - PROD_W){1'b0}}, prod_r};
  assign dep_time = dep_sum[TIME_W] ? {TIME_W{1'b1}} : dep_sum[TIME_W-1:0];

  assign wr_entry.depart = dep_time;
  assign wr_entry.id     = id_r;
  assign wr_entry.len    = len_r;

  assign out_entry = hold_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    tail_dep_nxt   = tail_dep_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    wr_en          = 1'b0;
    out_push       = 1'b0;
    out_last       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // oversized arrivals are dropped on the spot
        if (in_accept &&
            !((in_tuser == CMD_ARRIVAL) && ({4'b0, in_len} > {{(LEN_W - CAP_W + 4){1'b0}},
                                                                cap_r}))) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stall) begin
          if (can_emit) begin
            // previous held departure is not the last one
            out_push       = hold_valid_r;
            out_last       = 1'b0;
            hold_nxt       = rd_entry;
            hold_valid_nxt = 1'b1;
            head_nxt       = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
            count_nxt      = count_r - 1'b1;
            bytes_nxt      = bytes_r - {{(BYTES_W - LEN_W){1'b0}}, rd_entry.len};
          end else begin
            // drain finished: mark the held departure as last, then admit
            out_push       = hold_valid_r;
            out_last       = 1'b1;
            hold_valid_nxt = 1'b0;
            if (admit) begin
              wr_en        = 1'b1;
              tail_nxt     = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
              count_nxt    = count_r + 1'b1;
              bytes_nxt    = bytes_after[BYTES_W-1:0];
              tail_dep_nxt = dep_time;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      bytes_r      <= '0;
      tail_dep_r   <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      tail_dep_r   <= tail_dep_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(500);
      tpb_r <= TPB_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAPACITY:      cap_r <= cfg_wdata[CAP_W-1:0];
        REG_TIME_PER_BYTE: tpb_r <= cfg_wdata;
        default:           cap_r <= cap_r;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (in_accept) begin
      flush_r <= (in_tuser == CMD_FLUSH);
      arr_r   <= in_arr;
      id_r    <= in_id;
      len_r   <= in_len;
      // transmit time product taken at accept, ready for the closing cycle
      prod_r  <= PROD_W'(in_len) * PROD_W'(tpb_r);
    end
  end

  ftdpq_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_nxt),
    .rd_data (rd_entry)
  );

  ftdpq_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (out_push),
    .push_entry (out_entry),
    .push_last  (out_last),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // occupancy never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // an empty queue holds no bytes
  a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (bytes_r == '0))
    else $error("bytes held while queue empty");

  // the hold slot is always flushed before the sequencer returns to idle
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("held departure left behind at idle");

  // a result is only pushed into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> out_free)
    else $error("output register overrun");

  // a store write advances the tail by exactly one slot
  a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (tail_r == (($past(tail_r) == LAST_SLOT) ? '0 : $past(tail_r) + 1'b1)))
    else $error("tail pointer step mismatch");

endmodule
